// ===== rtl/ilt_pkg.sv =====
package ilt_pkg;

  localparam int NUM_QUEUES      = 16;
  localparam int SLOTS_PER_QUEUE = 8;
  localparam int TXN_BITS        = 16;

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = $clog2(SLOTS_PER_QUEUE);
  localparam int LW = $clog2(SLOTS_PER_QUEUE + 1);

  localparam logic [1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_WAIT    = 2'd1;
  localparam logic [1:0] STATUS_NOSPACE = 2'd2;

  localparam logic [1:0] MODE_S  = 2'd0;
  localparam logic [1:0] MODE_X  = 2'd1;
  localparam logic [1:0] MODE_IS = 2'd2;
  localparam logic [1:0] MODE_IX = 2'd3;

  typedef struct packed {
    logic [TXN_BITS-1:0] txn;
    logic [1:0]          mode;
    logic                granted;
  } slot_t;

  typedef struct packed {
    logic [LW-1:0]                    len;
    slot_t [SLOTS_PER_QUEUE-1:0]      slots;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_LOOK, ST_ROW_RD, ST_ROW_LD, ST_OP,
    ST_REL_CHK, ST_COMPACT, ST_GRANT, ST_WB, ST_DONE
  } ilt_state_t;

  // bit b of a row set: requested mode compatible with held mode b
  function automatic logic compat(logic [1:0] req, logic [1:0] held);
    logic [3:0] row;
    begin
      unique case (req)
        MODE_S:  row = 4'd5;
        MODE_X:  row = 4'd0;
        MODE_IS: row = 4'd13;
        MODE_IX: row = 4'd12;
        default: row = 4'd0;
      endcase
      return row[held];
    end
  endfunction

endpackage

// ===== rtl/ilt_if.sv =====
interface ilt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] txn_id;
  logic [31:0] res_key;
  logic [1:0]  mode;
  modport source (output valid, req_type, txn_id, res_key, mode, input ready);
  modport sink (input valid, req_type, txn_id, res_key, mode, output ready);
endinterface

interface ilt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       holds;
  modport source (output valid, status, holds, input ready);
  modport sink (input valid, status, holds, output ready);
endinterface

// ===== rtl/intention_lock_table.sv =====
// channel  dir  payload                                   handshake
// req      in   req_type, txn_id, res_key, mode           valid/ready
// rsp      out  status, holds                             valid/ready
//
// acquire and query: the tag scan reads one queue tag entry a cycle
// release: every tagged queue row is compacted, then given a grant pass if an entry went,
//   one slot a cycle over the row memory
// one item at a time; the next item is taken while the result waits in rsp
// rst is synchronous; queue tags are marked free, memories are not cleared
// a stalled rsp holds the block in its last state until the result is taken
module intention_lock_table (
  input  logic      clk,
  input  logic      rst,
  ilt_req_if.sink   req,
  ilt_rsp_if.source rsp
);
  import ilt_pkg::*;

  localparam logic [QW-1:0] LAST_Q = QW'(NUM_QUEUES - 1);

  ilt_state_t state, state_next;

  logic [NUM_QUEUES-1:0] used;
  logic [31:0]           key_mem [NUM_QUEUES];
  row_t                  row_mem [NUM_QUEUES];
  logic [31:0]           key_rd;
  row_t                  row_rd;

  logic [1:0]          r_type;
  logic [TXN_BITS-1:0] r_txn;
  logic [31:0]         r_key;
  logic [1:0]          r_mode;

  logic [QW-1:0] scan_q, chk_q, cur_q, found_q, free_q;
  logic          chk_v, found, have_free;
  row_t          work;
  logic [LW-1:0] ci, wi, old_len;
  logic          changed;
  logic [1:0]    res_status;
  logic          res_holds;

  // acquire / query evaluation on the loaded row
  row_t          acq_row;
  logic [1:0]    acq_status;
  logic          any_hold, hit, fit_all, fit_skip;
  logic [SW-1:0] hi;
  logic          row_we;
  row_t          row_wd;
  slot_t         cslot, gslot;

  function automatic logic fits(row_t r, logic [1:0] m, logic skip_en, logic [SW-1:0] skip);
    logic ok;
    begin
      ok = 1'b1;
      for (int i = 0; i < SLOTS_PER_QUEUE; i++) begin
        if (LW'(i) < r.len && !(skip_en && skip == SW'(i)) && r.slots[i].granted &&
            !compat(m, r.slots[i].mode)) begin
          ok = 1'b0;
        end
      end
      return ok;
    end
  endfunction

  always_comb begin
    acq_row  = work;
    hit      = 1'b0;
    hi       = '0;
    any_hold = 1'b0;
    for (int i = 0; i < SLOTS_PER_QUEUE; i++) begin
      if (LW'(i) < work.len && work.slots[i].txn == r_txn) begin
        if (!hit) begin
          hit = 1'b1;
          hi  = SW'(i);
        end
        if (work.slots[i].granted) begin
          any_hold = 1'b1;
        end
      end
    end
    fit_all  = fits(work, r_mode, 1'b0, '0);
    fit_skip = fits(work, r_mode, 1'b1, hi);
    if (hit) begin
      if (work.slots[hi].granted) begin
        if (r_mode > work.slots[hi].mode) begin
          acq_row.slots[hi].mode = r_mode;
        end
        acq_status = STATUS_OK;
      end else begin
        acq_row.slots[hi].mode = r_mode;
        if (fit_skip) begin
          acq_row.slots[hi].granted = 1'b1;
          acq_status = STATUS_OK;
        end else begin
          acq_status = STATUS_WAIT;
        end
      end
    end else if (work.len >= LW'(SLOTS_PER_QUEUE)) begin
      acq_status = STATUS_NOSPACE;
    end else begin
      acq_row.slots[work.len[SW-1:0]].txn     = r_txn;
      acq_row.slots[work.len[SW-1:0]].mode    = r_mode;
      acq_row.slots[work.len[SW-1:0]].granted = fit_all;
      acq_row.len = work.len + LW'(1);
      acq_status  = fit_all ? STATUS_OK : STATUS_WAIT;
    end
  end

  assign cslot  = work.slots[ci[SW-1:0]];
  assign gslot  = work.slots[ci[SW-1:0]];
  assign row_we = (state == ST_WB) || (state == ST_OP && r_type == REQ_ACQUIRE);
  assign row_wd = (state == ST_WB) ? work : acq_row;

  assign req.ready = (state == ST_IDLE);

  // memories
  always_ff @(posedge clk) begin
    key_rd <= key_mem[scan_q];
    row_rd <= row_mem[cur_q];
    if (state == ST_LOOK && r_type == REQ_ACQUIRE && !found && have_free) begin
      key_mem[free_q] <= r_key;
    end
    if (row_we) begin
      row_mem[cur_q] <= row_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.req_type == REQ_RELEASE) begin
            state_next = ST_REL_CHK;
          end else if (req.req_type == REQ_ACQUIRE || req.req_type == REQ_QUERY) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (chk_v && chk_q == LAST_Q) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (found) begin
          state_next = ST_ROW_RD;
        end else if (r_type == REQ_ACQUIRE && have_free) begin
          state_next = ST_OP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ROW_RD: state_next = ST_ROW_LD;
      ST_ROW_LD: state_next = (r_type == REQ_RELEASE) ? ST_COMPACT : ST_OP;
      ST_OP:     state_next = ST_DONE;
      ST_REL_CHK: begin
        if (used[cur_q]) begin
          state_next = ST_ROW_RD;
        end else if (cur_q == LAST_Q) begin
          state_next = ST_DONE;
        end
      end
      ST_COMPACT: begin
        if (ci == old_len) begin
          state_next = changed ? ST_GRANT : ST_WB;
        end
      end
      ST_GRANT: begin
        if (ci == work.len) begin
          state_next = ST_WB;
        end
      end
      ST_WB: state_next = (cur_q == LAST_Q) ? ST_DONE : ST_REL_CHK;
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (state == ST_LOOK && r_type == REQ_ACQUIRE && !found && have_free) begin
        used[free_q] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        r_type     <= req.req_type;
        r_txn      <= req.txn_id[TXN_BITS-1:0];
        r_key      <= req.res_key;
        r_mode     <= req.mode;
        scan_q     <= '0;
        chk_v      <= 1'b0;
        found      <= 1'b0;
        have_free  <= 1'b0;
        cur_q      <= '0;
        res_status <= STATUS_OK;
        res_holds  <= 1'b0;
      end
      ST_SCAN: begin
        scan_q <= scan_q + QW'(1);
        chk_q  <= scan_q;
        chk_v  <= 1'b1;
        if (chk_v) begin
          if (used[chk_q] && key_rd == r_key && !found) begin
            found   <= 1'b1;
            found_q <= chk_q;
          end
          if (!used[chk_q] && !have_free) begin
            have_free <= 1'b1;
            free_q    <= chk_q;
          end
        end
      end
      ST_LOOK: begin
        if (found) begin
          cur_q <= found_q;
        end else if (r_type == REQ_ACQUIRE && have_free) begin
          cur_q    <= free_q;
          work.len <= '0;
        end else if (r_type == REQ_ACQUIRE) begin
          res_status <= STATUS_NOSPACE;
        end
      end
      ST_ROW_LD: begin
        work    <= row_rd;
        old_len <= row_rd.len;
        ci      <= '0;
        wi      <= '0;
        changed <= 1'b0;
      end
      ST_OP: begin
        if (r_type == REQ_ACQUIRE) begin
          res_status <= acq_status;
        end else begin
          res_holds <= any_hold;
        end
      end
      ST_REL_CHK: begin
        if (!used[cur_q] && cur_q != LAST_Q) begin
          cur_q <= cur_q + QW'(1);
        end
      end
      ST_COMPACT: begin
        if (ci == old_len) begin
          work.len <= wi;
          ci       <= '0;
        end else begin
          ci <= ci + LW'(1);
          if (cslot.txn == r_txn) begin
            changed <= 1'b1;
          end else begin
            work.slots[wi[SW-1:0]] <= cslot;
            wi <= wi + LW'(1);
          end
        end
      end
      ST_GRANT: begin
        if (ci != work.len) begin
          ci <= ci + LW'(1);
          // waiters are granted in order against the current granted set
          if (!gslot.granted && fits(work, gslot.mode, 1'b1, ci[SW-1:0])) begin
            work.slots[ci[SW-1:0]].granted <= 1'b1;
          end
        end
      end
      ST_WB: begin
        if (cur_q != LAST_Q) begin
          cur_q <= cur_q + QW'(1);
        end
      end
      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          rsp.status <= res_status;
          rsp.holds  <= res_holds;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_ready_drops: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("ready stayed high after an accepted item");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_OP |-> work.len <= LW'(SLOTS_PER_QUEUE))
    else $error("queue length beyond slot count");
  a_holds_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.holds |-> rsp.status == STATUS_OK)
    else $error("holds set with a non-ok status");
  a_found_used: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOOK && found |-> used[found_q])
    else $error("matched queue is not tagged");
`endif

endmodule

// ===== test/ilt_checker.sv =====
module ilt_checker (
  input  logic      clk,
  input  logic      rst,
  ilt_req_if        req,
  ilt_rsp_if        rsp,
  output int        pending,
  output int        errors
);
  import ilt_pkg::*;

  localparam int TOTAL = NUM_QUEUES * SLOTS_PER_QUEUE;

  typedef struct {
    logic [1:0] status;
    logic       holds;
  } lock_answer_t;

  logic                tag_used [NUM_QUEUES];
  logic [31:0]         tag_key  [NUM_QUEUES];
  int                  row_len  [NUM_QUEUES];
  logic [TXN_BITS-1:0] ent_txn  [TOTAL];
  logic [1:0]          ent_mode [TOTAL];
  logic                ent_gnt  [TOTAL];

  lock_answer_t answers_due[$];

  function automatic logic modes_fit(logic [1:0] want, logic [1:0] held);
    logic [3:0] row;
    case (want)
      MODE_S:  row = 4'b0101;
      MODE_IS: row = 4'b1101;
      MODE_IX: row = 4'b1100;
      default: row = 4'b0000;
    endcase
    return row[held];
  endfunction

  function automatic int find_tag(logic [31:0] key);
    for (int q = 0; q < NUM_QUEUES; q++)
      if (tag_used[q] && tag_key[q] == key) return q;
    return -1;
  endfunction

  // skip = -1 checks against every granted entry
  function automatic logic fits_holders(int q, logic [1:0] m, int skip);
    int b;
    b = q * SLOTS_PER_QUEUE;
    for (int i = 0; i < row_len[q]; i++)
      if (i != skip && ent_gnt[b+i] && !modes_fit(m, ent_mode[b+i])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [1:0] predict_acquire(logic [TXN_BITS-1:0] t, logic [31:0] key,
                                                 logic [1:0] m);
    int q, b, n;
    logic ok;
    q = find_tag(key);
    if (q < 0) begin
      q = 0;
      while (q < NUM_QUEUES && tag_used[q]) q++;
      if (q >= NUM_QUEUES) return STATUS_NOSPACE;
      tag_used[q] = 1'b1;
      tag_key[q] = key;
      row_len[q] = 0;
    end
    b = q * SLOTS_PER_QUEUE;
    n = row_len[q];
    for (int i = 0; i < n; i++) begin
      if (ent_txn[b+i] != t) continue;
      if (ent_gnt[b+i]) begin
        if (m > ent_mode[b+i]) ent_mode[b+i] = m;
        return STATUS_OK;
      end
      ent_mode[b+i] = m;
      if (fits_holders(q, m, i)) begin
        ent_gnt[b+i] = 1'b1;
        return STATUS_OK;
      end
      return STATUS_WAIT;
    end
    ok = fits_holders(q, m, -1);
    if (n >= SLOTS_PER_QUEUE) return STATUS_NOSPACE;
    ent_txn[b+n] = t;
    ent_mode[b+n] = m;
    ent_gnt[b+n] = ok;
    row_len[q] = n + 1;
    return ok ? STATUS_OK : STATUS_WAIT;
  endfunction

  function automatic void lock_release(logic [TXN_BITS-1:0] t);
    int b, w;
    logic hit;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (!tag_used[q]) continue;
      b = q * SLOTS_PER_QUEUE;
      w = 0;
      hit = 1'b0;
      for (int i = 0; i < row_len[q]; i++) begin
        if (ent_txn[b+i] == t) begin
          hit = 1'b1;
          continue;
        end
        ent_txn[b+w] = ent_txn[b+i];
        ent_mode[b+w] = ent_mode[b+i];
        ent_gnt[b+w] = ent_gnt[b+i];
        w++;
      end
      row_len[q] = w;
      if (!hit) continue;
      // waiters granted in order, each against holders granted so far
      for (int i = 0; i < w; i++)
        if (!ent_gnt[b+i] && fits_holders(q, ent_mode[b+i], i)) ent_gnt[b+i] = 1'b1;
    end
  endfunction

  function automatic logic lock_held(logic [TXN_BITS-1:0] t, logic [31:0] key);
    int q, b;
    q = find_tag(key);
    if (q < 0) return 1'b0;
    b = q * SLOTS_PER_QUEUE;
    for (int i = 0; i < row_len[q]; i++)
      if (ent_txn[b+i] == t && ent_gnt[b+i]) return 1'b1;
    return 1'b0;
  endfunction

  assign pending = answers_due.size();

  always @(posedge clk) begin
    lock_answer_t exp_a;
    logic bad;
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) tag_used[q] = 1'b0;
      answers_due.delete();
      errors <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $error("result with no item outstanding: status %0d holds %0d",
                 rsp.status, rsp.holds);
          errors <= errors + 1;
        end else begin
          exp_a = answers_due.pop_front();
          bad = 1'b0;
          if (rsp.status !== exp_a.status) begin
            $error("status: expected %0d, actual %0d", exp_a.status, rsp.status);
            bad = 1'b1;
          end
          if (rsp.holds !== exp_a.holds) begin
            $error("holds: expected %0d, actual %0d", exp_a.holds, rsp.holds);
            bad = 1'b1;
          end
          if (bad) begin
            errors <= errors + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        exp_a.status = STATUS_OK;
        exp_a.holds = 1'b0;
        case (req.req_type)
          REQ_ACQUIRE: exp_a.status = predict_acquire(req.txn_id[TXN_BITS-1:0],
                                                      req.res_key, req.mode);
          REQ_RELEASE: lock_release(req.txn_id[TXN_BITS-1:0]);
          REQ_QUERY:   exp_a.holds = lock_held(req.txn_id[TXN_BITS-1:0], req.res_key);
          default: ;
        endcase
        answers_due.push_back(exp_a);
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import ilt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   pending;
  int   errors;
  int   send_idle = 0;
  int   rsp_idle = 0;
  int   cycles = 0;
  logic [31:0] keys [20];

  ilt_req_if req ();
  ilt_rsp_if rsp ();

  intention_lock_table i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  ilt_checker i_checker (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                         .pending(pending), .errors(errors));

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk)
    rsp.ready = rst ? 1'b0 : ($urandom_range(99) >= rsp_idle);

  task automatic send(logic [1:0] kind, logic [15:0] t, logic [31:0] key, logic [1:0] m);
    while ($urandom_range(99) < send_idle) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.req_type = kind;
    req.txn_id = t;
    req.res_key = key;
    req.mode = m;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  initial begin
    int r;
    logic [15:0] t;
    req.valid = 1'b0;
    req.req_type = REQ_ACQUIRE;
    req.txn_id = '0;
    req.res_key = '0;
    req.mode = MODE_S;
    rsp.ready = 1'b0;
    keys[0] = 32'h0;
    keys[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 20; i++) keys[i] = $urandom;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // compatibility, waiting, upgrade and queries
    send(REQ_QUERY,   16'd0,    keys[0], MODE_S);
    send(REQ_ACQUIRE, 16'd0,    keys[0], MODE_S);
    send(REQ_ACQUIRE, 16'd1,    keys[0], MODE_IS);
    send(REQ_ACQUIRE, 16'hFFFF, keys[0], MODE_X);
    send(REQ_QUERY,   16'd0,    keys[0], MODE_S);
    send(REQ_QUERY,   16'hFFFF, keys[0], MODE_S);
    send(REQ_ACQUIRE, 16'd0,    keys[0], MODE_IX);
    send(REQ_ACQUIRE, 16'hFFFF, keys[0], MODE_IS);
    send(REQ_RELEASE, 16'd0,    keys[0], MODE_S);
    send(REQ_QUERY,   16'hFFFF, keys[0], MODE_S);
    // x raised to a higher code
    send(REQ_ACQUIRE, 16'd2,    keys[1], MODE_X);
    send(REQ_ACQUIRE, 16'd2,    keys[1], MODE_IX);
    send(REQ_ACQUIRE, 16'd3,    keys[1], MODE_IX);
    // queue full, then an emptied queue stays tagged
    for (int i = 0; i < 9; i++) send(REQ_ACQUIRE, 16'(10 + i), keys[2], MODE_IS);
    for (int i = 0; i < 8; i++) send(REQ_RELEASE, 16'(10 + i), keys[2], MODE_S);
    send(REQ_QUERY,   16'd10,   keys[2], MODE_S);
    wait (pending == 0);

    for (int n = 0; n < 650; n++) begin
      if (n == 0)   begin send_idle = 26; rsp_idle = 77; end
      if (n == 216) begin send_idle = 77; rsp_idle = 26; end
      if (n == 433) begin send_idle = 0;  rsp_idle = 0;  end
      if (n == 300) wait (pending == 0);
      t = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      r = $urandom_range(99);
      if (r < 60)
        send(REQ_ACQUIRE, t, keys[$urandom_range(19)], 2'($urandom_range(3)));
      else if (r < 75)
        send(REQ_RELEASE, t, $urandom, 2'($urandom_range(3)));
      else
        send(REQ_QUERY, t, keys[$urandom_range(19)], 2'($urandom_range(3)));
    end

    wait (pending == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
